// ===== hw/rtl/cwm_pkg.sv =====
// Shared types and constants for the 2D convolution window MAC core.
package cwm_pkg;

  // Field widths.
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = COEF_W + PIX_W + 1;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int SUM_W      = PROD_W + 4;
  localparam int OUT_W      = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Largest supported kernel side.
  localparam int MAX_KERNEL = 3;

  // Output saturation limits.
  localparam logic signed [SUM_W-1:0] SUM_LOW  = -29'sd37601280;
  localparam logic signed [SUM_W-1:0] SUM_HIGH = 29'sd37598985;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_TOP     = 3'd0,
    CFG_COEF_MID     = 3'd1,
    CFG_COEF_BOTTOM  = 3'd2,
    CFG_KERNEL_SIDE  = 3'd3,
    CFG_PAD_WIDTH    = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cwm_cfg_idx_t;

  // Window: [row][col], row 0 on top, col 0 the oldest column.
  typedef logic [2:0][2:0][PIX_W-1:0] cwm_win_t;

  // Coefficients: [kernel row][kernel col], two's complement Q1.14.
  typedef logic [2:0][2:0][COEF_W-1:0] cwm_coef_t;

  // Per-stage item tag.
  typedef struct packed {
    logic vld;
    logic emit;
    logic last;
  } cwm_tag_t;

  // Load enables for the MAC pipeline registers.
  typedef struct packed {
    logic prod_en;
    logic rsum_en;
    logic out_en;
  } cwm_mac_ctl_t;

endpackage

// ===== hw/rtl/conv2d_window_mac_core.sv =====
// An accepted item goes through the stage 1, window, product, row sum and output registers to the out port.
// Throughput: one grid position per cycle while the output is not stalled; a stage moves whenever
// the stage after it is empty or moving, so up to four more items are taken while a result waits.
// The line stores are read at one address and written at one address per cycle.
// Reset (rst_n low, synchronous) clears the pipeline, the grid position, the window
// and the registers to their defaults; line store contents are undefined until written.
module conv2d_window_mac_core
  import cwm_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIX_W-1:0]        in_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_conv_sum,
  output logic                    out_frame_end,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int ROW_LEN = MAX_WIDTH + 4;
  localparam int IDX_W   = $clog2(ROW_LEN);
  localparam int DIM_W   = $clog2(ROW_LEN + 1);
  localparam int W_RST   = (32 > MAX_WIDTH) ? MAX_WIDTH : 32;
  localparam int K_RST   = (3 > MAX_KERNEL) ? MAX_KERNEL : 3;

  // Configuration, kept in saturated form.
  cwm_coef_t        coef_r;
  logic [1:0]       k_r;
  logic [1:0]       p_r;
  logic [DIM_W-1:0] w_r;
  logic [DIM_W-1:0] h_r;

  // Grid position.
  logic [DIM_W-1:0] col_r;
  logic [DIM_W-1:0] row_r;

  // Stage 1: accepted item and line store read data.
  cwm_tag_t         tag1_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [PIX_W-1:0] rd_top_r;
  logic [PIX_W-1:0] rd_mid_r;

  // Later stage tags and window.
  cwm_tag_t tag2_r;
  cwm_tag_t tag3_r;
  cwm_tag_t tag4_r;
  cwm_win_t win_r;

  logic out_valid_r;
  logic out_frame_end_r;

  // Line stores: previous two grid rows.
  logic [PIX_W-1:0] top_mem [ROW_LEN];
  logic [PIX_W-1:0] mid_mem [ROW_LEN];

  logic [DIM_W-1:0] pw;
  logic [DIM_W-1:0] ph;
  logic [DIM_W-1:0] p_ext;
  logic [DIM_W-1:0] k_ext;
  logic [DIM_W-1:0] col_p1;
  logic [DIM_W-1:0] row_p1;
  logic             interior;
  logic [PIX_W-1:0] pix0;
  logic [IDX_W-1:0] idx0;
  cwm_tag_t         tag0;
  logic             accept;
  logic             load_out;
  logic             load_4;
  logic             load_3;
  logic             load_2;
  logic             wr;
  logic             fwd;
  logic [1:0]       k_nxt;
  logic [1:0]       p_nxt;
  logic [DIM_W-1:0] w_nxt;
  logic [DIM_W-1:0] h_nxt;
  logic [31:0]      w_val;
  logic [31:0]      h_val;
  cwm_mac_ctl_t     mac_ctl;

  // Stage load enables, from the output back to the input.
  assign load_out = !out_valid_r || out_ready;
  assign load_4   = !tag4_r.vld || load_out;
  assign load_3   = !tag3_r.vld || load_4;
  assign load_2   = !tag2_r.vld || load_3;
  assign in_ready = !tag1_r.vld || load_2;
  assign accept   = in_valid && in_ready;

  // Grid geometry and position decode.
  always_comb begin
    p_ext    = DIM_W'(p_r);
    k_ext    = DIM_W'(k_r);
    pw       = w_r + DIM_W'({p_r, 1'b0});
    ph       = h_r + DIM_W'({p_r, 1'b0});
    col_p1   = col_r + DIM_W'(1);
    row_p1   = row_r + DIM_W'(1);
    interior = (row_r >= p_ext) && (row_r < p_ext + h_r) &&
               (col_r >= p_ext) && (col_r < p_ext + w_r);
    pix0     = interior ? in_pixel : '0;
    idx0     = col_r[IDX_W-1:0];
    tag0.vld  = accept;
    tag0.emit = (row_p1 >= k_ext) && (col_p1 >= k_ext);
    tag0.last = (row_p1 == ph) && (col_p1 == pw);
  end

  // The stage 1 item writes the line stores as it moves on; the next item may read
  // the same column in that cycle and then takes the new bytes directly.
  assign wr  = tag1_r.vld && load_2;
  assign fwd = wr && (s1_idx_r == idx0);

  // Saturated values of geometry writes.
  always_comb begin
    w_val = {25'b0, cfg_wdata[6:0]};
    h_val = {25'b0, cfg_wdata[6:0]};
    if (cfg_wdata[1:0] == 2'd0) begin
      k_nxt = 2'd1;
    end else if (32'(cfg_wdata[1:0]) > 32'(MAX_KERNEL)) begin
      k_nxt = 2'(MAX_KERNEL);
    end else begin
      k_nxt = cfg_wdata[1:0];
    end
    p_nxt = (cfg_wdata[1:0] == 2'd3) ? 2'd2 : cfg_wdata[1:0];
    if (w_val == 32'd0) begin
      w_nxt = DIM_W'(1);
    end else if (w_val > 32'(MAX_WIDTH)) begin
      w_nxt = DIM_W'(MAX_WIDTH);
    end else begin
      w_nxt = DIM_W'(w_val);
    end
    if (h_val == 32'd0) begin
      h_nxt = DIM_W'(1);
    end else if (h_val > 32'(MAX_WIDTH)) begin
      h_nxt = DIM_W'(MAX_WIDTH);
    end else begin
      h_nxt = DIM_W'(h_val);
    end
  end

  // Configuration registers and grid position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      k_r    <= 2'(K_RST);
      p_r    <= 2'd1;
      w_r    <= DIM_W'(W_RST);
      h_r    <= DIM_W'(W_RST);
      col_r  <= '0;
      row_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_TOP:    coef_r[0] <= cfg_wdata;
        CFG_COEF_MID:    coef_r[1] <= cfg_wdata;
        CFG_COEF_BOTTOM: coef_r[2] <= cfg_wdata;
        CFG_KERNEL_SIDE: begin
          k_r   <= k_nxt;
          col_r <= '0;
          row_r <= '0;
        end
        CFG_PAD_WIDTH: begin
          p_r   <= p_nxt;
          col_r <= '0;
          row_r <= '0;
        end
        CFG_IMAGE_WIDTH: begin
          w_r   <= w_nxt;
          col_r <= '0;
          row_r <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          h_r   <= h_nxt;
          col_r <= '0;
          row_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_p1 >= pw) begin
        col_r <= '0;
        row_r <= (row_p1 >= ph) ? '0 : row_p1;
      end else begin
        col_r <= col_p1;
      end
    end
  end

  // Line stores: read on accept, written when the stage 1 item moves on.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_top_r <= fwd ? rd_mid_r : top_mem[idx0];
      rd_mid_r <= fwd ? s1_pix_r : mid_mem[idx0];
      s1_pix_r <= pix0;
      s1_idx_r <= idx0;
    end
    if (wr) begin
      top_mem[s1_idx_r] <= rd_mid_r;
      mid_mem[s1_idx_r] <= s1_pix_r;
    end
  end

  // Window shift: one new column per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (wr) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= rd_top_r;
      win_r[1][2] <= rd_mid_r;
      win_r[2][2] <= s1_pix_r;
    end
  end

  // Item tags through the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      tag3_r      <= '0;
      tag4_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) tag1_r <= tag0;
      if (load_2)   tag2_r <= tag1_r;
      if (load_3)   tag3_r <= tag2_r;
      if (load_4)   tag4_r <= tag3_r;
      if (load_out) out_valid_r <= tag4_r.vld && tag4_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_frame_end_r <= tag4_r.last;
    end
  end

  // Products load with stage 3, row sums with stage 4, the sum with the output.
  always_comb begin
    mac_ctl.prod_en = load_3;
    mac_ctl.rsum_en = load_4;
    mac_ctl.out_en  = load_out;
  end

  cwm_mac u_mac (
    .clk      (clk),
    .window   (win_r),
    .coef     (coef_r),
    .ksize    (k_r),
    .ctl      (mac_ctl),
    .conv_sum (out_conv_sum)
  );

  assign out_valid     = out_valid_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ===== hw/rtl/cwm_mac.sv =====
// Multiply-accumulate datapath: nine products, row sums, final sum with saturation.
module cwm_mac
  import cwm_pkg::*;
(
  input  logic                    clk,
  input  cwm_win_t                window,
  input  cwm_coef_t               coef,
  input  logic [1:0]              ksize,
  input  cwm_mac_ctl_t            ctl,
  output logic signed [OUT_W-1:0] conv_sum
);

  logic [COEF_W-1:0]        coef_sel [3][3];
  logic [PIX_W-1:0]         win_sel  [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic signed [RSUM_W-1:0] rsum_nxt [3];
  logic signed [RSUM_W-1:0] rsum_r   [3];
  logic signed [SUM_W-1:0]  total;
  logic signed [OUT_W-1:0]  conv_sum_nxt;
  logic signed [OUT_W-1:0]  conv_sum_r;

  // Align the kernel with the bottom-right corner of the window; taps outside
  // the kernel take zero for both operands.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef_sel[i][j] = '0;
        win_sel[i][j]  = '0;
      end
    end
    unique case (ksize)
      2'd1: begin
        coef_sel[2][2] = coef[0][0];
        win_sel[2][2]  = window[2][2];
      end
      2'd2: begin
        for (int i = 0; i < 2; i++) begin
          for (int j = 0; j < 2; j++) begin
            coef_sel[i+1][j+1] = coef[i][j];
            win_sel[i+1][j+1]  = window[i+1][j+1];
          end
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            coef_sel[i][j] = coef[i][j];
            win_sel[i][j]  = window[i][j];
          end
        end
      end
    endcase
  end

  // Nine products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed(coef_sel[i][j]) * $signed({1'b0, win_sel[i][j]});
      end
    end
  end

  // Sum each window row.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum_nxt[i] = RSUM_W'(prod_r[i][0]) + RSUM_W'(prod_r[i][1]) + RSUM_W'(prod_r[i][2]);
    end
  end

  // Final sum, clamped to the output range.
  always_comb begin
    total = SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);
    if (total < SUM_LOW) begin
      conv_sum_nxt = OUT_W'(SUM_LOW);
    end else if (total > SUM_HIGH) begin
      conv_sum_nxt = OUT_W'(SUM_HIGH);
    end else begin
      conv_sum_nxt = OUT_W'(total);
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.rsum_en) begin
      rsum_r <= rsum_nxt;
    end
    if (ctl.out_en) begin
      conv_sum_r <= conv_sum_nxt;
    end
  end

  assign conv_sum = conv_sum_r;

endmodule

// ===== hw/rtl/cwm_checker.sv =====
// Port-level checks for the convolution window MAC core, bound to the top level.
module cwm_checker
  import cwm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_conv_sum,
  input logic                    out_frame_end
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_conv_sum) &&
                                $stable(out_frame_end))
    else $error("result changed while stalled");

  // Every result lies inside the clamped range.
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SUM_W'(out_conv_sum) >= SUM_LOW) && (SUM_W'(out_conv_sum) <= SUM_HIGH))
    else $error("result outside saturation range");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Reset empties the input stage, so an item can be taken right away.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind conv2d_window_mac_core cwm_checker u_cwm_checker (.*);
